### hw/rtl/tcpct_pkg.sv
`timescale 1ns / 1ps
package tcpct_pkg;

  localparam int MAX_CONN_DEFAULT = 1024;
  localparam int COUNT_W          = 40;
  localparam int IN_TDATA_W       = 152;
  localparam int OUT_TDATA_W      = 104;
  localparam int STATUS_W         = 3;
  localparam logic [31:0] TIMEOUT_RESET = 32'd60;

  // register index, taken from paddr[2]
  localparam logic REG_EXPIRY_TIMEOUT = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED = 3'd0,
    ST_CREATED = 3'd1,
    ST_UPDATED = 3'd2,
    ST_CLOSED  = 3'd3,
    ST_FULL    = 3'd4,
    ST_EXPIRY  = 3'd5
  } status_t;

  // one table entry
  typedef struct packed {
    logic               valid;
    logic [63:0]        addrs;
    logic [31:0]        ports;
    logic [31:0]        last_seen;
    logic [COUNT_W-1:0] up;
    logic [COUNT_W-1:0] down;
  } entry_t;

  // age-list write port
  typedef struct packed {
    logic we;
  } wr_en_t;

endpackage

### hw/rtl/tcpct_data_mem.sv
`timescale 1ns / 1ps
module tcpct_data_mem #(
  parameter int DEPTH = tcpct_pkg::MAX_CONN_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  tcpct_pkg::entry_t  wdata,
  input  logic [AW-1:0]      raddr,
  output tcpct_pkg::entry_t  rdata
);
  import tcpct_pkg::*;

  entry_t mem [DEPTH];

  // one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tcpct_link_mem.sv
`timescale 1ns / 1ps
module tcpct_link_mem #(
  parameter int DEPTH = tcpct_pkg::MAX_CONN_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          nxt_we,
  input  logic [AW-1:0] nxt_waddr,
  input  logic [LW-1:0] nxt_wdata,
  input  logic          prv_we,
  input  logic [AW-1:0] prv_waddr,
  input  logic [LW-1:0] prv_wdata,
  input  logic [AW-1:0] raddr,
  output logic [LW-1:0] nxt_rdata,
  output logic [LW-1:0] prv_rdata
);

  logic [LW-1:0] nxt_mem [DEPTH];
  logic [LW-1:0] prv_mem [DEPTH];

  // newer-to-older links
  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    nxt_rdata <= nxt_mem[raddr];
  end

  // older-to-newer links
  always_ff @(posedge clk) begin
    if (prv_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
    prv_rdata <= prv_mem[raddr];
  end

endmodule

### hw/rtl/tcp_connection_tracker.sv
`timescale 1ns / 1ps
// Packet item: the table is scanned one entry a cycle, stopping at a hit; an update ends there,
// a create goes on through S_CR_RD, S_CR_WR and, unless the list is empty, S_CR_LNK; a close
// through S_F_RD, S_F_WR1, S_F_WR2. Expiry tick: per expired connection read, check, unlink, free.
// One item at a time; the next is taken once the result register has been emptied.
// After reset an init sweep clears the table and builds the free chain; in_tready stays low
// meanwhile. Config writes are taken at any time.
module tcp_connection_tracker #(
  parameter int MAX_CONNECTIONS = tcpct_pkg::MAX_CONN_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // src_address, dst_address, src_port, dst_port, syn, ack, rst, fin, payload_bytes, time_now
  input  logic [tcpct_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // direction, slot, uploaded_bytes, downloaded_bytes, expired_count
  output logic [tcpct_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status
  output logic [tcpct_pkg::STATUS_W-1:0]      out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import tcpct_pkg::*;

  localparam int SW = $clog2(MAX_CONNECTIONS);
  localparam int LW = $clog2(MAX_CONNECTIONS + 1);
  localparam logic [LW-1:0] NIL = LW'(MAX_CONNECTIONS);
  localparam logic [LW-1:0] LAST_IDX = LW'(MAX_CONNECTIONS - 1);

  typedef enum logic [10:0] {
    S_INIT   = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_SCAN   = 11'b00000000100,
    S_CR_RD  = 11'b00000001000,
    S_CR_WR  = 11'b00000010000,
    S_CR_LNK = 11'b00000100000,
    S_F_RD   = 11'b00001000000,
    S_F_WR1  = 11'b00010000000,
    S_F_WR2  = 11'b00100000000,
    S_E_RD   = 11'b01000000000,
    S_E_CHK  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // config register
  logic [31:0] timeout_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_EXPIRY_TIMEOUT) begin
      timeout_r <= cfg_pwdata;
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_EXPIRY_TIMEOUT) ? timeout_r : 32'd0;

  // control state
  logic [LW-1:0] newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [LW-1:0] free_r, free_nxt, live_r, live_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [SW-1:0] chk_idx_r, chk_idx_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic          out_valid_r, out_valid_nxt;

  // item payload
  logic          cmd_r, cmd_nxt;
  logic [63:0]   key_addr_r, key_addr_nxt;
  logic [31:0]   key_port_r, key_port_nxt;
  logic          syn_r, syn_nxt, ack_r, ack_nxt, close_r, close_nxt;
  logic [15:0]   pay_r, pay_nxt;
  logic [31:0]   now_r, now_nxt;

  // result fields
  status_t              o_status_r, o_status_nxt;
  logic                 o_dir_r, o_dir_nxt;
  logic [SW-1:0]        o_slot_r, o_slot_nxt;
  logic [COUNT_W-1:0]   o_up_r, o_up_nxt, o_down_r, o_down_nxt;
  logic [LW-1:0]        o_exp_r, o_exp_nxt;

  // memory ports
  logic          d_we;
  logic [SW-1:0] d_waddr, d_raddr;
  entry_t        d_wdata, d_rdata;
  logic          n_we, p_we;
  logic [SW-1:0] n_waddr, p_waddr, l_raddr;
  logic [LW-1:0] n_wdata, p_wdata, n_rdata, p_rdata;

  tcpct_data_mem #(.DEPTH(MAX_CONNECTIONS), .AW(SW)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  tcpct_link_mem #(.DEPTH(MAX_CONNECTIONS), .AW(SW), .LW(LW)) u_link (
    .clk(clk),
    .nxt_we(n_we), .nxt_waddr(n_waddr), .nxt_wdata(n_wdata),
    .prv_we(p_we), .prv_waddr(p_waddr), .prv_wdata(p_wdata),
    .raddr(l_raddr), .nxt_rdata(n_rdata), .prv_rdata(p_rdata)
  );

  // item fields
  logic        in_dir;
  logic [15:0] in_sport, in_dport;
  assign in_sport = in_tdata[79:64];
  assign in_dport = in_tdata[95:80];
  assign in_dir   = (in_sport < in_dport);

  // scan compare and counter update
  logic               hit;
  logic [COUNT_W:0]   up_sum, down_sum;
  logic [COUNT_W-1:0] add_up, add_down, up_sat, down_sat;
  logic [32:0]        limit;

  assign hit = d_rdata.valid && d_rdata.addrs == key_addr_r && d_rdata.ports == key_port_r;
  assign add_up   = o_dir_r ? '0 : COUNT_W'(pay_r);
  assign add_down = o_dir_r ? COUNT_W'(pay_r) : '0;
  assign up_sum   = {1'b0, d_rdata.up} + {1'b0, add_up};
  assign down_sum = {1'b0, d_rdata.down} + {1'b0, add_down};
  assign up_sat   = up_sum[COUNT_W] ? '1 : up_sum[COUNT_W-1:0];
  assign down_sat = down_sum[COUNT_W] ? '1 : down_sum[COUNT_W-1:0];
  assign limit    = {1'b0, d_rdata.last_seen} + {1'b0, timeout_r};

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    free_nxt      = free_r;
    live_nxt      = live_r;
    idx_nxt       = idx_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    key_addr_nxt  = key_addr_r;
    key_port_nxt  = key_port_r;
    syn_nxt       = syn_r;
    ack_nxt       = ack_r;
    close_nxt     = close_r;
    pay_nxt       = pay_r;
    now_nxt       = now_r;
    o_status_nxt  = o_status_r;
    o_dir_nxt     = o_dir_r;
    o_slot_nxt    = o_slot_r;
    o_up_nxt      = o_up_r;
    o_down_nxt    = o_down_r;
    o_exp_nxt     = o_exp_r;
    d_we    = 1'b0;
    d_waddr = cur_r;
    d_wdata = '0;
    d_raddr = idx_r[SW-1:0];
    n_we    = 1'b0;
    n_waddr = cur_r;
    n_wdata = NIL;
    p_we    = 1'b0;
    p_waddr = cur_r;
    p_wdata = NIL;
    l_raddr = cur_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // clear entries and chain free slots in index order
      S_INIT: begin
        d_we    = 1'b1;
        d_waddr = idx_r[SW-1:0];
        n_we    = 1'b1;
        n_waddr = idx_r[SW-1:0];
        n_wdata = idx_r + LW'(1);
        idx_nxt = idx_r + LW'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_nxt      = in_tuser[0];
          syn_nxt      = in_tdata[96];
          ack_nxt      = in_tdata[97];
          close_nxt    = in_tdata[98] | in_tdata[99];
          pay_nxt      = in_tdata[115:100];
          now_nxt      = in_tdata[147:116];
          o_slot_nxt   = '0;
          o_up_nxt     = '0;
          o_down_nxt   = '0;
          o_exp_nxt    = '0;
          idx_nxt      = '0;
          if (in_dir) begin
            key_addr_nxt = {in_tdata[63:32], in_tdata[31:0]};
            key_port_nxt = {in_dport, in_sport};
          end else begin
            key_addr_nxt = {in_tdata[31:0], in_tdata[63:32]};
            key_port_nxt = {in_sport, in_dport};
          end
          if (in_tuser[0]) begin
            o_status_nxt = ST_EXPIRY;
            o_dir_nxt    = 1'b0;
            state_nxt    = S_E_RD;
          end else begin
            o_status_nxt = ST_IGNORED;
            o_dir_nxt    = in_dir;
            state_nxt    = S_SCAN;
          end
        end
      end

      // read one entry a cycle, compare the one read last cycle
      S_SCAN: begin
        if (idx_r != NIL) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[SW-1:0];
          idx_nxt     = idx_r + LW'(1);
        end
        if (chk_vld_r && hit) begin
          o_slot_nxt = chk_idx_r;
          cur_nxt    = chk_idx_r;
          if (close_r) begin
            o_status_nxt = ST_CLOSED;
            o_up_nxt     = d_rdata.up;
            o_down_nxt   = d_rdata.down;
            state_nxt    = S_F_RD;
          end else begin
            d_we              = 1'b1;
            d_waddr           = chk_idx_r;
            d_wdata           = d_rdata;
            d_wdata.last_seen = now_r;
            d_wdata.up        = up_sat;
            d_wdata.down      = down_sat;
            o_status_nxt      = ST_UPDATED;
            o_up_nxt          = up_sat;
            o_down_nxt        = down_sat;
            out_valid_nxt     = 1'b1;
            state_nxt         = S_IDLE;
          end
        end else if (idx_r == NIL) begin
          if (!(syn_r && ack_r)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (live_r >= NIL || free_r == NIL) begin
            o_status_nxt  = ST_FULL;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cur_nxt   = free_r[SW-1:0];
            state_nxt = S_CR_RD;
          end
        end
      end

      S_CR_RD: begin
        state_nxt = S_CR_WR;
      end

      // take the free head, link it as newest, write the entry
      S_CR_WR: begin
        free_nxt        = n_rdata;
        n_we            = 1'b1;
        n_wdata         = newest_r;
        p_we            = 1'b1;
        p_wdata         = NIL;
        d_we            = 1'b1;
        d_wdata.valid   = 1'b1;
        d_wdata.addrs   = key_addr_r;
        d_wdata.ports   = key_port_r;
        d_wdata.last_seen = now_r;
        d_wdata.up      = add_up;
        d_wdata.down    = add_down;
        live_nxt        = live_r + LW'(1);
        o_status_nxt    = ST_CREATED;
        o_slot_nxt      = cur_r;
        o_up_nxt        = add_up;
        o_down_nxt      = add_down;
        if (newest_r != NIL) begin
          state_nxt = S_CR_LNK;
        end else begin
          oldest_nxt    = LW'(cur_r);
          newest_nxt    = LW'(cur_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_CR_LNK: begin
        p_we          = 1'b1;
        p_waddr       = newest_r[SW-1:0];
        p_wdata       = LW'(cur_r);
        newest_nxt    = LW'(cur_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_F_RD: begin
        state_nxt = S_F_WR1;
      end

      // unlink from the age list, invalidate
      S_F_WR1: begin
        n_we    = (p_rdata != NIL);
        n_waddr = p_rdata[SW-1:0];
        n_wdata = n_rdata;
        p_we    = (n_rdata != NIL);
        p_waddr = n_rdata[SW-1:0];
        p_wdata = p_rdata;
        d_we    = 1'b1;
        if (newest_r == LW'(cur_r)) begin
          newest_nxt = n_rdata;
        end
        if (oldest_r == LW'(cur_r)) begin
          oldest_nxt = p_rdata;
        end
        state_nxt = S_F_WR2;
      end

      // push onto the free chain
      S_F_WR2: begin
        n_we     = 1'b1;
        n_wdata  = free_r;
        free_nxt = LW'(cur_r);
        if (live_r != '0) begin
          live_nxt = live_r - LW'(1);
        end
        if (cmd_r) begin
          o_exp_nxt = o_exp_r + LW'(1);
          state_nxt = S_E_RD;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_E_RD: begin
        d_raddr = oldest_r[SW-1:0];
        if (oldest_r == NIL) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_E_CHK;
        end
      end

      // oldest entry still live ends the walk
      S_E_CHK: begin
        if (limit > {1'b0, now_r}) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cur_nxt   = oldest_r[SW-1:0];
          state_nxt = S_F_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      newest_r    <= NIL;
      oldest_r    <= NIL;
      free_r      <= '0;
      live_r      <= '0;
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      free_r      <= free_nxt;
      live_r      <= live_nxt;
      idx_r       <= idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    cur_r      <= cur_nxt;
    cmd_r      <= cmd_nxt;
    key_addr_r <= key_addr_nxt;
    key_port_r <= key_port_nxt;
    syn_r      <= syn_nxt;
    ack_r      <= ack_nxt;
    close_r    <= close_nxt;
    pay_r      <= pay_nxt;
    now_r      <= now_nxt;
    o_status_r <= o_status_nxt;
    o_dir_r    <= o_dir_nxt;
    o_slot_r   <= o_slot_nxt;
    o_up_r     <= o_up_nxt;
    o_down_r   <= o_down_nxt;
    o_exp_r    <= o_exp_nxt;
  end

  // result packing
  logic [SW+9:0] slot_ext;
  logic [LW+10:0] exp_ext;
  assign slot_ext = {10'd0, o_slot_r};
  assign exp_ext  = {11'd0, o_exp_r};

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {2'b00, exp_ext[10:0], o_down_r, o_up_r, slot_ext[9:0], o_dir_r};

endmodule
